// File: rtl/selective_repeat_receiver_core_defines.svh
// Assertion macros for the selective repeat receiver.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef SELECTIVE_REPEAT_RECEIVER_CORE_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_CORE_DEFINES_SVH

// same-cycle implication
`define SRR_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define SRR_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: rtl/srr_pkg.sv
// Shared types, constants and the byte-sum function of the receiver.
// No dependencies.
`timescale 1ns / 1ps

package srr_pkg;

   localparam int WINDOW_MAX_DEF = 32;
   localparam int WIN_W          = 6;
   localparam int SEQ_W          = 31;
   localparam int PAY_BYTES      = 20;
   localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(8);

   typedef struct packed {
      logic [31:0] high;
      logic [63:0] mid;
      logic [63:0] low;
   } srr_pay_type;

   typedef enum logic {
      KIND_DELIVER = 1'b0,
      KIND_ACK     = 1'b1
   } srr_kind_type;

   // sum of the 20 payload bytes, each read as signed, sign-extended to 32 bits
   function automatic logic [31:0] byte_sum(input srr_pay_type pay);
      logic [12:0] acc;
      logic [7:0]  b;
      acc = '0;
      for (int i = 0; i < PAY_BYTES; i++) begin
         b   = pay[8*i +: 8];
         acc = acc + {{5{b[7]}}, b};
      end
      return {{19{acc[12]}}, acc};
   endfunction

endpackage

// File: rtl/srr_if.sv
// Request and response channel interfaces of the receiver.
// Depends on srr_pkg.
`timescale 1ns / 1ps

interface srr_req_if import srr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SEQ_W-1:0]   seq;
   logic signed [31:0] ack;
   logic signed [31:0] checksum;
   logic [63:0]        pay_low;
   logic [63:0]        pay_mid;
   logic [31:0]        pay_high;

   modport source(output valid, seq, ack, checksum, pay_low, pay_mid, pay_high,
                  input ready);
   modport sink(input valid, seq, ack, checksum, pay_low, pay_mid, pay_high,
                output ready);
endinterface

interface srr_rsp_if import srr_pkg::*; ();
   logic               valid;
   logic               ready;
   srr_kind_type       kind;
   logic [SEQ_W-1:0]   seq;
   logic signed [31:0] ack;
   logic signed [31:0] checksum;
   logic [63:0]        pay_low;
   logic [63:0]        pay_mid;
   logic [31:0]        pay_high;
   logic               last;

   modport source(output valid, kind, seq, ack, checksum, pay_low, pay_mid, pay_high,
                  last, input ready);
   modport sink(input valid, kind, seq, ack, checksum, pay_low, pay_mid, pay_high,
                last, output ready);
endinterface

// File: rtl/selective_repeat_receiver_core.sv
// Selective repeat receiver core. A packet is taken when req_port.ready is high, which
// is whenever reset is low and no earlier packet is still in work; a finished response
// may still wait in the output register. A packet with a bad checksum gives nothing.
// An out-of-window packet gives one ack. An in-window packet gives the n in-order
// payloads it releases (up to the window size), followed by the ack; the payload
// memory's single read port sets the one delivery per cycle, while the response side
// accepts. A response-side stall holds the core, and after the window size is lowered
// the first packet may first fold the head slot back into the window.
// Depends on srr_pkg, srr_if, srr_cksum, srr_slot_mem and the assertion macro header.
`timescale 1ns / 1ps
`include "selective_repeat_receiver_core_defines.svh"

module selective_repeat_receiver_core import srr_pkg::*; #(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   srr_req_if.sink          req_port,
   srr_rsp_if.source        rsp_port,
   input  logic             csr_we,
   input  logic [WIN_W-1:0] csr_wdata
);

   localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam logic [CNT_W-1:0] WMAX      = CNT_W'(WINDOW_MAX);
   localparam logic [WIN_W:0]   WIN_LIMIT = (WIN_W + 1)'(WINDOW_MAX);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_CHECK,
      ST_EVAL,
      ST_NORM,
      ST_FIRST,
      ST_SHOW,
      ST_ACK
   } state_type;

   state_type         state_ff, state_in;
   logic [WIN_W-1:0]  win_ff, win_in;
   logic [31:0]       base_ff, base_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [WINDOW_MAX-1:0] full_ff, full_in;

   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [31:0]       ack_ff, ack_in;
   logic [31:0]       cks_ff, cks_in;
   srr_pay_type       pay_ff, pay_in;
   logic [SLOT_W-1:0] hw_ff, hw_in;        // working head, folded into the window
   logic [CNT_W-1:0]  off_ff, off_in;
   logic              inwin_ff, inwin_in;
   logic [SEQ_W-1:0]  dseq_ff, dseq_in;

   logic              rsp_valid_ff, rsp_valid_in;
   srr_kind_type      rsp_kind_ff, rsp_kind_in;
   logic [SEQ_W-1:0]  rsp_seq_ff, rsp_seq_in;
   logic [31:0]       rsp_ack_ff, rsp_ack_in;
   logic [31:0]       rsp_cks_ff, rsp_cks_in;
   srr_pay_type       rsp_pay_ff, rsp_pay_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]  eff_w;
   logic              cks_ok;
   logic [31:0]       ack_cks;
   logic              mem_wr_en;
   logic [SLOT_W-1:0] mem_wr_addr;
   logic              mem_rd_en;
   srr_pay_type       mem_rd_data;
   logic              rsp_free;
   logic              issue;
   logic              load_dlv;
   logic              load_ack;
   logic [CNT_W:0]    hw_inc;
   logic [SLOT_W-1:0] hw_next;
   logic [CNT_W:0]    slot_sum;
   logic [CNT_W:0]    slot_wide;
   logic [31:0]       off32;

   srr_cksum u_cksum (
      .clock   (clock),
      .seq     (seq_ff),
      .ack     (ack_ff),
      .cks     (cks_ff),
      .pay     (pay_ff),
      .cks_ok  (cks_ok),
      .ack_cks (ack_cks)
   );

   srr_slot_mem #(
      .DEPTH  (WINDOW_MAX),
      .ADDR_W (SLOT_W)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (pay_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (hw_ff),
      .rd_data (mem_rd_data)
   );

   // effective window: 0 acts as 1, clipped at the slot count
   always_comb begin
      if (win_ff == '0) begin
         eff_w = CNT_W'(1);
      end else if ({1'b0, win_ff} > WIN_LIMIT) begin
         eff_w = WMAX;
      end else begin
         eff_w = CNT_W'(win_ff);
      end
   end

   assign off32     = {1'b0, seq_ff} - base_ff;
   assign hw_inc    = {1'b0, CNT_W'(hw_ff)} + (CNT_W + 1)'(1);
   assign hw_next   = (hw_inc == {1'b0, eff_w}) ? '0 : SLOT_W'(hw_inc);
   assign slot_sum  = {1'b0, CNT_W'(hw_ff)} + {1'b0, off_ff};
   assign slot_wide = (slot_sum >= {1'b0, eff_w}) ? (slot_sum - {1'b0, eff_w}) : slot_sum;
   assign rsp_free  = !rsp_valid_ff || rsp_port.ready;

   always_comb begin
      state_in     = state_ff;
      win_in       = csr_we ? csr_wdata : win_ff;
      base_in      = base_ff;
      head_in      = head_ff;
      full_in      = full_ff;
      seq_in       = seq_ff;
      ack_in       = ack_ff;
      cks_in       = cks_ff;
      pay_in       = pay_ff;
      hw_in        = hw_ff;
      off_in       = off_ff;
      inwin_in     = inwin_ff;
      dseq_in      = dseq_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_seq_in   = rsp_seq_ff;
      rsp_ack_in   = rsp_ack_ff;
      rsp_cks_in   = rsp_cks_ff;
      rsp_pay_in   = rsp_pay_ff;
      rsp_last_in  = rsp_last_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = SLOT_W'(slot_wide);
      issue        = 1'b0;
      load_dlv     = 1'b0;
      load_ack     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               seq_in   = req_port.seq;
               ack_in   = req_port.ack;
               cks_in   = req_port.checksum;
               pay_in   = '{high: req_port.pay_high, mid: req_port.pay_mid,
                            low: req_port.pay_low};
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            inwin_in = (off32 < {{(32 - CNT_W){1'b0}}, eff_w});
            off_in   = off32[CNT_W-1:0];
            hw_in    = head_ff;
            state_in = cks_ok ? ST_NORM : ST_IDLE;
         end
         ST_NORM: begin
            if (CNT_W'(hw_ff) >= eff_w) begin
               hw_in = SLOT_W'(CNT_W'(hw_ff) - eff_w);
            end else if (inwin_ff) begin
               mem_wr_en            = 1'b1;
               full_in[mem_wr_addr] = 1'b1;
               state_in             = ST_FIRST;
            end else begin
               state_in = ST_ACK;
            end
         end
         ST_FIRST: begin
            if (full_ff[hw_ff]) begin
               issue    = 1'b1;
               state_in = ST_SHOW;
            end else begin
               state_in = ST_ACK;
            end
         end
         ST_SHOW: begin
            // present the slot already read and, when the response side is free, fetch the next one
            if (rsp_free) begin
               load_dlv = 1'b1;
               if (full_ff[hw_ff]) begin
                  issue = 1'b1;
               end else begin
                  state_in = ST_ACK;
               end
            end
         end
         ST_ACK: begin
            if (rsp_free) begin
               load_ack = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (issue) begin
         full_in[hw_ff] = 1'b0;
         hw_in          = hw_next;
         head_in        = hw_next;
         dseq_in        = base_ff[SEQ_W-1:0];
         base_in        = base_ff + 32'd1;
      end

      if (load_dlv) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_DELIVER;
         rsp_seq_in   = dseq_ff;
         rsp_ack_in   = '0;
         rsp_cks_in   = '0;
         rsp_pay_in   = mem_rd_data;
         rsp_last_in  = 1'b0;
      end else if (load_ack) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_ACK;
         rsp_seq_in   = seq_ff;
         rsp_ack_in   = {1'b0, seq_ff};
         rsp_cks_in   = ack_cks;
         rsp_pay_in   = pay_ff;
         rsp_last_in  = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign mem_rd_en = issue;

   always_ff @(posedge clock) begin
      seq_ff      <= seq_in;
      ack_ff      <= ack_in;
      cks_ff      <= cks_in;
      pay_ff      <= pay_in;
      hw_ff       <= hw_in;
      off_ff      <= off_in;
      inwin_ff    <= inwin_in;
      dseq_ff     <= dseq_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_seq_ff  <= rsp_seq_in;
      rsp_ack_ff  <= rsp_ack_in;
      rsp_cks_ff  <= rsp_cks_in;
      rsp_pay_ff  <= rsp_pay_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_ff       <= WIN_RESET;
         base_ff      <= '0;
         head_ff      <= '0;
         full_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         base_ff      <= base_in;
         head_ff      <= head_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_port.ready    = (state_ff == ST_IDLE) && !reset;
   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.kind     = rsp_kind_ff;
   assign rsp_port.seq      = rsp_seq_ff;
   assign rsp_port.ack      = rsp_ack_ff;
   assign rsp_port.checksum = rsp_cks_ff;
   assign rsp_port.pay_low  = rsp_pay_ff.low;
   assign rsp_port.pay_mid  = rsp_pay_ff.mid;
   assign rsp_port.pay_high = rsp_pay_ff.high;
   assign rsp_port.last     = rsp_last_ff;

   `SRR_ASSERT_NEXT(a_issue_advances_base, issue, base_ff == ($past(base_ff) + 32'd1), "base did not advance on delivery")
   `SRR_ASSERT_NEXT(a_issue_clears_slot, issue, !full_ff[$past(hw_ff)], "delivered slot still marked full")
   `SRR_ASSERT_NEXT(a_store_marks_slot, mem_wr_en, full_ff[$past(mem_wr_addr)], "stored slot not marked full")
   `SRR_ASSERT_NOW(a_head_in_window, (state_ff == ST_FIRST) || (state_ff == ST_SHOW), CNT_W'(hw_ff) < eff_w, "working head outside window")
   `SRR_ASSERT_NOW(a_last_is_ack, rsp_valid_ff, rsp_last_ff == (rsp_kind_ff == KIND_ACK), "last flag and kind disagree")

endmodule

// File: rtl/srr_slot_mem.sv
// Payload slot memory: one write port, one read port, registered read data.
// Depends on srr_pkg.
`timescale 1ns / 1ps

module srr_slot_mem import srr_pkg::*; #(
   parameter int DEPTH  = WINDOW_MAX_DEF,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  srr_pay_type       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output srr_pay_type       rd_data
);

   srr_pay_type slot_mem_ff [DEPTH];
   srr_pay_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/srr_cksum.sv
// Two-stage checksum unit: registered byte sum, then check and ack checksum.
// Depends on srr_pkg.
`timescale 1ns / 1ps

module srr_cksum import srr_pkg::*; (
   input  logic             clock,
   input  logic [SEQ_W-1:0] seq,
   input  logic [31:0]      ack,
   input  logic [31:0]      cks,
   input  srr_pay_type      pay,
   output logic             cks_ok,
   output logic [31:0]      ack_cks
);

   logic [31:0] bsum_ff;
   logic [31:0] bsum_in;
   logic        ok_ff;
   logic        ok_in;
   logic [31:0] ack_cks_ff;
   logic [31:0] ack_cks_in;
   logic [31:0] seq32;

   assign seq32      = {1'b0, seq};
   assign bsum_in    = byte_sum(pay);
   assign ok_in      = ((seq32 + ack + bsum_ff) == cks);
   // ack packet carries ack = seq
   assign ack_cks_in = seq32 + seq32 + bsum_ff;

   always_ff @(posedge clock) begin
      bsum_ff    <= bsum_in;
      ok_ff      <= ok_in;
      ack_cks_ff <= ack_cks_in;
   end

   assign cks_ok  = ok_ff;
   assign ack_cks = ack_cks_ff;

endmodule
